// File: rtl/dcp_pkg.sv
// Shared constants and types for the depth-to-colour palette block.
`timescale 1ns / 1ps
package dcp_pkg;

  // register indexes (word address)
  localparam logic [2:0] REG_ROI_MODE      = 3'd0;
  localparam logic [2:0] REG_CUSTOM_START  = 3'd1;
  localparam logic [2:0] REG_CUSTOM_END    = 3'd2;
  localparam logic [2:0] REG_REVERSE_ORDER = 3'd3;
  localparam logic [2:0] REG_GRAY_MODE     = 3'd4;

  // window modes
  localparam logic [2:0] ROI_NORMAL = 3'd0;
  localparam logic [2:0] ROI_NEAR   = 3'd1;
  localparam logic [2:0] ROI_MIDDLE = 3'd2;
  localparam logic [2:0] ROI_FAR    = 3'd3;
  localparam logic [2:0] ROI_CUSTOM = 3'd4;

  localparam int unsigned Q_BITS = 16;

  localparam logic [16:0] Q_ONE      = 17'd65536;
  localparam logic [16:0] V_LOW      = 17'd6554;
  localparam logic [15:0] V_SPAN     = 16'd52428;
  localparam logic [19:0] SEXT       = 20'd131072;
  localparam logic [19:0] HUE_DARK   = 20'd655;
  localparam logic [14:0] CUSTOM_END_RST = 15'd16384;
  localparam logic [7:0]  ALPHA_ON   = 8'hFF;
  localparam logic [7:0]  CHAN_FULL  = 8'hFF;

  // hue sextant: first letter is the channel held at full, second the ramped one
  typedef enum logic [2:0] {
    SEG_BLACK,
    SEG_RG,
    SEG_GR,
    SEG_GB,
    SEG_BG,
    SEG_BR
  } hue_seg_e;

endpackage

// File: rtl/depth_to_color_palette_top.sv
// Depth-to-colour palette: pipelined window, ramp divider and hue/gray mapping.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  input    | in_valid_i/ready_o  | depth_index_i[13:0]
//  output   | out_valid_o/ready_i | red_o, green_o, blue_o, alpha_o [7:0]
//  config   | APB psel/penable    | paddr[4:0], pwdata/prdata[31:0]
//
// One beat per clock while the output accepts it; stages are window, multiply,
// 16 restoring-divide stages, value, hue, output register.
// The divide stages (one quotient bit each) set the depth of the pipe.
// Reset clears the valid bits and loads register defaults; no clearing pass.
// A stall at the output holds every stage; nothing is lost or repeated.
`timescale 1ns / 1ps
module depth_to_color_palette_top #(
  parameter int unsigned PALETTE_ENTRIES = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [13:0] depth_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned NW = $clog2(PALETTE_ENTRIES + 1);
  localparam int unsigned AW = (NW > 15) ? NW : 15;
  localparam int unsigned QW = dcp_pkg::Q_BITS;
  localparam int unsigned MW = NW + QW;

  localparam logic [NW-1:0] N_VAL     = NW'(PALETTE_ENTRIES);
  localparam logic [NW-1:0] NEAR_LO   = NW'(PALETTE_ENTRIES * 5 / 10);
  localparam logic [NW-1:0] NEAR_HI   = NW'(PALETTE_ENTRIES * 8 / 10);
  localparam logic [NW-1:0] MID_LO    = NW'(PALETTE_ENTRIES * 3 / 10);
  localparam logic [NW-1:0] MID_HI    = NW'(PALETTE_ENTRIES * 7 / 10);
  localparam logic [NW-1:0] FAR_LO    = NW'(PALETTE_ENTRIES * 2 / 10);
  localparam logic [NW-1:0] FAR_HI    = NW'(PALETTE_ENTRIES * 6 / 10);

  // configuration registers
  logic [2:0]  roi_mode_q;
  logic [14:0] custom_start_q;
  logic [14:0] custom_end_q;
  logic        reverse_order_q;
  logic        gray_mode_q;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roi_mode_q      <= dcp_pkg::ROI_NORMAL;
      custom_start_q  <= '0;
      custom_end_q    <= dcp_pkg::CUSTOM_END_RST;
      reverse_order_q <= 1'b0;
      gray_mode_q     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        dcp_pkg::REG_ROI_MODE:      roi_mode_q      <= pwdata[2:0];
        dcp_pkg::REG_CUSTOM_START:  custom_start_q  <= pwdata[14:0];
        dcp_pkg::REG_CUSTOM_END:    custom_end_q    <= pwdata[14:0];
        dcp_pkg::REG_REVERSE_ORDER: reverse_order_q <= pwdata[0];
        dcp_pkg::REG_GRAY_MODE:     gray_mode_q     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      dcp_pkg::REG_ROI_MODE:      prdata = {29'd0, roi_mode_q};
      dcp_pkg::REG_CUSTOM_START:  prdata = {17'd0, custom_start_q};
      dcp_pkg::REG_CUSTOM_END:    prdata = {17'd0, custom_end_q};
      dcp_pkg::REG_REVERSE_ORDER: prdata = {31'd0, reverse_order_q};
      dcp_pkg::REG_GRAY_MODE:     prdata = {31'd0, gray_mode_q};
      default:                    prdata = '0;
    endcase
  end

  // global advance: the whole pipe moves unless the output beat is held
  logic en;
  logic out_valid_q;
  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;

  // ---- window stage ----
  logic [NW-1:0] win_lo, win_hi, cs_cl, ce_cl;
  logic [AW-1:0] cs_ext, ce_ext, n_ext, idx_ext, d_ext;
  logic          win_full, in_win;

  assign n_ext   = AW'(PALETTE_ENTRIES);
  assign cs_ext  = AW'(custom_start_q);
  assign ce_ext  = AW'(custom_end_q);
  assign idx_ext = AW'(depth_index_i);

  always_comb begin
    cs_cl = (cs_ext < n_ext) ? cs_ext[NW-1:0] : N_VAL;
    ce_cl = (ce_ext < n_ext) ? ce_ext[NW-1:0] : N_VAL;
    unique case (roi_mode_q)
      dcp_pkg::ROI_NEAR: begin
        win_lo = NEAR_LO; win_hi = NEAR_HI; win_full = 1'b0;
      end
      dcp_pkg::ROI_MIDDLE: begin
        win_lo = MID_LO;  win_hi = MID_HI;  win_full = 1'b0;
      end
      dcp_pkg::ROI_FAR: begin
        win_lo = FAR_LO;  win_hi = FAR_HI;  win_full = 1'b0;
      end
      dcp_pkg::ROI_CUSTOM: begin
        win_lo   = (cs_cl > ce_cl) ? ce_cl : cs_cl;
        win_hi   = ce_cl;
        win_full = 1'b1;
      end
      default: begin
        win_lo = '0; win_hi = N_VAL; win_full = 1'b1;
      end
    endcase
  end

  assign in_win = (idx_ext >= AW'(win_lo)) && (idx_ext < AW'(win_hi));
  assign d_ext  = idx_ext - AW'(win_lo);

  logic          a_valid_q, a_win_q, a_full_q;
  logic [NW-1:0] a_d_q, a_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_win_q  <= in_win;
      a_full_q <= win_full;
      a_d_q    <= d_ext[NW-1:0];
      a_den_q  <= win_hi - win_lo;
    end
  end

  // ---- multiply stage (entry 0) and divide stages (entries 1..QW) ----
  logic          dv_valid_q [QW+1];
  logic          dv_win_q   [QW+1];
  logic          dv_full_q  [QW+1];
  logic [NW-1:0] dv_den_q   [QW+1];
  logic [NW-1:0] dv_rem_q   [QW+1];
  logic [QW-1:0] dv_lo_q    [QW+1];
  logic [QW-1:0] dv_quo_q   [QW+1];

  logic [MW-1:0] num;
  logic [NW:0]   trial [QW];
  logic [NW:0]   tsub  [QW];
  logic          ge    [QW];

  assign num = a_full_q ? {a_d_q, {QW{1'b0}}}
                        : MW'(a_d_q) * MW'(dcp_pkg::V_SPAN);

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      trial[k] = {dv_rem_q[k], dv_lo_q[k][QW-1]};
      tsub[k]  = trial[k] - {1'b0, dv_den_q[k]};
      ge[k]    = trial[k] >= {1'b0, dv_den_q[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QW; k++) dv_valid_q[k] <= 1'b0;
    end else if (en) begin
      dv_valid_q[0] <= a_valid_q;
      for (int k = 1; k <= QW; k++) dv_valid_q[k] <= dv_valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_win_q[0]  <= a_win_q;
      dv_full_q[0] <= a_full_q;
      dv_den_q[0]  <= a_den_q;
      dv_rem_q[0]  <= num[MW-1:QW];
      dv_lo_q[0]   <= num[QW-1:0];
      dv_quo_q[0]  <= '0;
      for (int k = 1; k <= QW; k++) begin
        dv_win_q[k]  <= dv_win_q[k-1];
        dv_full_q[k] <= dv_full_q[k-1];
        dv_den_q[k]  <= dv_den_q[k-1];
        dv_rem_q[k]  <= ge[k-1] ? tsub[k-1][NW-1:0] : trial[k-1][NW-1:0];
        dv_lo_q[k]   <= {dv_lo_q[k-1][QW-2:0], 1'b0};
        dv_quo_q[k]  <= {dv_quo_q[k-1][QW-2:0], ge[k-1]};
      end
    end
  end

  // ---- value stage ----
  logic [16:0] v_ramp, v_d;
  logic        v_valid_q, v_win_q;
  logic [16:0] v_q;

  assign v_ramp = (dv_full_q[QW] ? 17'd0 : dcp_pkg::V_LOW) + {1'b0, dv_quo_q[QW]};
  assign v_d    = reverse_order_q ? (dcp_pkg::Q_ONE - v_ramp) : v_ramp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_valid_q <= 1'b0;
    end else if (en) begin
      v_valid_q <= dv_valid_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      v_win_q <= dv_win_q[QW];
      v_q     <= v_d;
    end
  end

  // ---- hue sextant stage ----
  logic [19:0]       hq;
  logic [23:0]       gprod;
  dcp_pkg::hue_seg_e seg_d;
  logic [19:0]       cnum_w;
  logic              h_valid_q, h_win_q;
  dcp_pkg::hue_seg_e h_seg_q;
  logic [17:0]       h_cnum_q;
  logic [7:0]        h_gray_q;

  assign hq    = {v_q, 3'b000} + {3'b000, v_q};
  assign gprod = {v_q[15:0], 8'd0} + {v_q[16], 23'd0} + {v_q[16], 23'd0}
                 - {7'd0, v_q};

  always_comb begin
    priority if (hq <= dcp_pkg::HUE_DARK) begin
      seg_d = dcp_pkg::SEG_BLACK; cnum_w = '0;
    end else if (hq <= dcp_pkg::SEXT) begin
      seg_d = dcp_pkg::SEG_RG; cnum_w = hq;
    end else if (hq <= 20'(2 * dcp_pkg::SEXT)) begin
      seg_d = dcp_pkg::SEG_GR; cnum_w = 20'(2 * dcp_pkg::SEXT) - hq;
    end else if (hq <= 20'(3 * dcp_pkg::SEXT)) begin
      seg_d = dcp_pkg::SEG_GB; cnum_w = hq - 20'(2 * dcp_pkg::SEXT);
    end else if (hq <= 20'(4 * dcp_pkg::SEXT)) begin
      seg_d = dcp_pkg::SEG_BG; cnum_w = 20'(4 * dcp_pkg::SEXT) - hq;
    end else if (hq <= 20'(9 * dcp_pkg::SEXT / 2)) begin
      seg_d = dcp_pkg::SEG_BR; cnum_w = hq - 20'(4 * dcp_pkg::SEXT);
    end else begin
      seg_d = dcp_pkg::SEG_BLACK; cnum_w = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_valid_q <= 1'b0;
    end else if (en) begin
      h_valid_q <= v_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_win_q  <= v_win_q;
      h_seg_q  <= seg_d;
      h_cnum_q <= cnum_w[17:0];
      h_gray_q <= gprod[23:16];
    end
  end

  // ---- channel scale and output register ----
  logic [25:0] cprod;
  logic [7:0]  chan;
  logic [7:0]  red_d, green_d, blue_d, alpha_d;
  logic [7:0]  red_q, green_q, blue_q, alpha_q;

  assign cprod = {h_cnum_q, 8'd0} - {8'd0, h_cnum_q};
  assign chan  = cprod[24:17];

  always_comb begin
    red_d = '0; green_d = '0; blue_d = '0; alpha_d = '0;
    if (h_win_q) begin
      alpha_d = dcp_pkg::ALPHA_ON;
      if (gray_mode_q) begin
        red_d = h_gray_q; green_d = h_gray_q; blue_d = h_gray_q;
      end else begin
        unique case (h_seg_q)
          dcp_pkg::SEG_RG: begin red_d   = dcp_pkg::CHAN_FULL; green_d = chan; end
          dcp_pkg::SEG_GR: begin green_d = dcp_pkg::CHAN_FULL; red_d   = chan; end
          dcp_pkg::SEG_GB: begin green_d = dcp_pkg::CHAN_FULL; blue_d  = chan; end
          dcp_pkg::SEG_BG: begin blue_d  = dcp_pkg::CHAN_FULL; green_d = chan; end
          dcp_pkg::SEG_BR: begin blue_d  = dcp_pkg::CHAN_FULL; red_d   = chan; end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= h_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      alpha_q <= alpha_d;
    end
  end

  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;
  assign alpha_o = alpha_q;

endmodule

// File: rtl/dcp_checker.sv
// Port-level checker for the depth-to-colour palette, with its bind.
`timescale 1ns / 1ps
module dcp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] red_o,
  input logic [7:0] green_o,
  input logic [7:0] blue_o,
  input logic [7:0] alpha_o
);

  // outside the window every channel is zero
  a_clear_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && alpha_o == 8'd0 |-> red_o == 8'd0 && green_o == 8'd0 && blue_o == 8'd0)
    else $error("non-zero colour with zero alpha");

  a_alpha_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> alpha_o == 8'd0 || alpha_o == dcp_pkg::ALPHA_ON)
    else $error("alpha neither clear nor opaque");

  // an empty output register never back-pressures the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_o) && $stable(green_o)
      && $stable(blue_o) && $stable(alpha_o))
    else $error("held beat changed");

endmodule

bind depth_to_color_palette_top dcp_checker u_dcp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .red_o       (red_o),
  .green_o     (green_o),
  .blue_o      (blue_o),
  .alpha_o     (alpha_o)
);

// File: dv/tb_depth_to_color_palette_top.sv
// Self-checking testbench for the depth-to-colour palette block: directed table, random phases.
`timescale 1ns / 1ps
module tb_depth_to_color_palette_top;

  localparam longint unsigned N_ENTRIES = 16384;
  localparam longint unsigned Q1 = 65536;
  localparam longint unsigned VLO = 6554;
  localparam longint unsigned VHI = 58982;
  localparam longint unsigned SX = 131072;
  localparam int PIPE_LAT = 21;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASES = 12;
  localparam int PHASE_BEATS = 140;
  localparam int N_ROWS = 25;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } rgba_t;

  typedef struct packed {
    logic [13:0] idx;
    rgba_t       px;
  } pix_exp_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [14:0] cs;
    logic [14:0] ce;
    logic        rev;
    logic        gray;
    logic [13:0] idx;
    logic        typed;
    rgba_t       px;
  } dir_row_t;

  localparam rgba_t PX_BLACK = '{8'd0, 8'd0, 8'd0, 8'hFF};
  localparam rgba_t PX_CLEAR = '{8'd0, 8'd0, 8'd0, 8'd0};
  localparam rgba_t PX_WHITE = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};

  // mode, start, end, reverse, gray, index, typed, pixel
  localparam dir_row_t DIR_ROWS [N_ROWS] = '{
    '{dcp_pkg::ROI_NORMAL, 15'd0, 15'd16384, 1'b0, 1'b0, 14'd0, 1'b1, PX_BLACK},
    '{dcp_pkg::ROI_NORMAL, 15'd0, 15'd16384, 1'b0, 1'b0, 14'd18, 1'b1, PX_BLACK},
    '{dcp_pkg::ROI_NORMAL, 15'd0, 15'd16384, 1'b0, 1'b0, 14'd19, 1'b0, PX_CLEAR},
    '{dcp_pkg::ROI_NORMAL, 15'd0, 15'd16384, 1'b0, 1'b0, 14'd16383, 1'b0, PX_CLEAR},
    '{dcp_pkg::ROI_NORMAL, 15'd0, 15'd16384, 1'b1, 1'b0, 14'd0, 1'b0, PX_CLEAR},
    '{dcp_pkg::ROI_NORMAL, 15'd0, 15'd16384, 1'b1, 1'b0, 14'd16383, 1'b0, PX_CLEAR},
    '{dcp_pkg::ROI_NORMAL, 15'd0, 15'd16384, 1'b0, 1'b1, 14'd0, 1'b1, PX_BLACK},
    '{dcp_pkg::ROI_NORMAL, 15'd0, 15'd16384, 1'b0, 1'b1, 14'd16383, 1'b0, PX_CLEAR},
    '{dcp_pkg::ROI_NORMAL, 15'd0, 15'd16384, 1'b1, 1'b1, 14'd0, 1'b1, PX_WHITE},
    '{dcp_pkg::ROI_NEAR, 15'd0, 15'd16384, 1'b0, 1'b0, 14'd8191, 1'b1, PX_CLEAR},
    '{dcp_pkg::ROI_NEAR, 15'd0, 15'd16384, 1'b0, 1'b0, 14'd8192, 1'b0, PX_CLEAR},
    '{dcp_pkg::ROI_NEAR, 15'd0, 15'd16384, 1'b0, 1'b0, 14'd13106, 1'b0, PX_CLEAR},
    '{dcp_pkg::ROI_NEAR, 15'd0, 15'd16384, 1'b0, 1'b0, 14'd13107, 1'b1, PX_CLEAR},
    '{dcp_pkg::ROI_MIDDLE, 15'd0, 15'd16384, 1'b0, 1'b0, 14'd4914, 1'b1, PX_CLEAR},
    '{dcp_pkg::ROI_MIDDLE, 15'd0, 15'd16384, 1'b0, 1'b0, 14'd4915, 1'b0, PX_CLEAR},
    '{dcp_pkg::ROI_MIDDLE, 15'd0, 15'd16384, 1'b0, 1'b0, 14'd11467, 1'b0, PX_CLEAR},
    '{dcp_pkg::ROI_FAR, 15'd0, 15'd16384, 1'b0, 1'b0, 14'd3275, 1'b1, PX_CLEAR},
    '{dcp_pkg::ROI_FAR, 15'd0, 15'd16384, 1'b0, 1'b0, 14'd9829, 1'b0, PX_CLEAR},
    '{dcp_pkg::ROI_FAR, 15'd0, 15'd16384, 1'b0, 1'b0, 14'd9830, 1'b1, PX_CLEAR},
    '{3'd7, 15'd0, 15'd16384, 1'b0, 1'b0, 14'd16383, 1'b0, PX_CLEAR},
    '{3'd5, 15'd0, 15'd16384, 1'b0, 1'b0, 14'd0, 1'b1, PX_BLACK},
    '{dcp_pkg::ROI_CUSTOM, 15'd100, 15'd50, 1'b0, 1'b0, 14'd75, 1'b1, PX_CLEAR},
    '{dcp_pkg::ROI_CUSTOM, 15'd32767, 15'd32767, 1'b0, 1'b0, 14'd16383, 1'b1, PX_CLEAR},
    '{dcp_pkg::ROI_CUSTOM, 15'd0, 15'd1, 1'b0, 1'b0, 14'd0, 1'b1, PX_BLACK},
    '{dcp_pkg::ROI_CUSTOM, 15'd0, 15'd1, 1'b0, 1'b0, 14'd1, 1'b1, PX_CLEAR}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [13:0] depth_index_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic [7:0]  alpha_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [2:0]  cfg_mode = dcp_pkg::ROI_NORMAL;
  logic [14:0] cfg_cs = 15'd0;
  logic [14:0] cfg_ce = dcp_pkg::CUSTOM_END_RST;
  logic        cfg_rev = 1'b0;
  logic        cfg_gray = 1'b0;

  pix_exp_t pix_q[$];
  pix_exp_t pix_head;
  int       err_cnt = 0;
  int       send_pct = 23;
  int       recv_pct = 45;
  bit       hold_req = 1'b0;
  int       stall_cnt = 0;

  depth_to_color_palette_top #(
    .PALETTE_ENTRIES(16384)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .depth_index_i(depth_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .alpha_o      (alpha_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void window_of(output longint unsigned lo, output longint unsigned hi,
                                    output longint unsigned v1, output longint unsigned v2);
    v1 = VLO;
    v2 = VHI;
    case (cfg_mode)
      dcp_pkg::ROI_NEAR: begin
        lo = N_ENTRIES * 5 / 10;
        hi = N_ENTRIES * 8 / 10;
      end
      dcp_pkg::ROI_MIDDLE: begin
        lo = N_ENTRIES * 3 / 10;
        hi = N_ENTRIES * 7 / 10;
      end
      dcp_pkg::ROI_FAR: begin
        lo = N_ENTRIES * 2 / 10;
        hi = N_ENTRIES * 6 / 10;
      end
      dcp_pkg::ROI_CUSTOM: begin
        lo = (cfg_cs < N_ENTRIES) ? longint'(cfg_cs) : N_ENTRIES;
        hi = (cfg_ce < N_ENTRIES) ? longint'(cfg_ce) : N_ENTRIES;
        if (lo > hi) lo = hi;
        v1 = 0;
        v2 = Q1;
      end
      default: begin
        lo = 0;
        hi = N_ENTRIES;
        v1 = 0;
        v2 = Q1;
      end
    endcase
  endfunction

  function automatic logic [7:0] ramp_chan(input longint unsigned num);
    longint unsigned c;
    c = (num * 255) / SX;
    return (c > 255) ? 8'hFF : c[7:0];
  endfunction

  function automatic rgba_t palette_entry(input logic [13:0] idx);
    longint unsigned lo, hi, v1, v2, v, hq, gv;
    rgba_t px;
    window_of(lo, hi, v1, v2);
    px = PX_CLEAR;
    if (idx < lo || idx >= hi) return px;
    v = v1 + ((v2 - v1) * (idx - lo)) / (hi - lo);
    if (v > Q1) v = Q1;
    if (cfg_rev) v = Q1 - v;
    px.a = 8'hFF;
    if (cfg_gray) begin
      gv = (v * 255) / Q1;
      px.r = (gv > 255) ? 8'hFF : gv[7:0];
      px.g = px.r;
      px.b = px.r;
    end else begin
      hq = v * 9;
      // dark below the first threshold and in the band just past 4.5 sextants
      if (hq > 655) begin
        if (hq <= SX) begin
          px.r = 8'hFF;
          px.g = ramp_chan(hq);
        end else if (hq <= 2 * SX) begin
          px.g = 8'hFF;
          px.r = ramp_chan(2 * SX - hq);
        end else if (hq <= 3 * SX) begin
          px.g = 8'hFF;
          px.b = ramp_chan(hq - 2 * SX);
        end else if (hq <= 4 * SX) begin
          px.b = 8'hFF;
          px.g = ramp_chan(4 * SX - hq);
        end else if (hq <= 9 * (SX / 2)) begin
          px.b = 8'hFF;
          px.r = ramp_chan(hq - 4 * SX);
        end else if (hq > 5 * SX) begin
          px.r = 8'hFF;
          px.b = (hq < 6 * SX) ? ramp_chan(6 * SX - hq) : 8'd0;
        end
      end
    end
    return px;
  endfunction

  function automatic logic [14:0] bound_pick();
    case ($urandom_range(0, 5))
      0: return 15'd0;
      1: return 15'd1;
      2: return 15'd16383;
      3: return 15'd16384;
      4: return 15'd32767;
      default: return 15'($urandom_range(0, 32767));
    endcase
  endfunction

  function automatic logic [13:0] depth_pick();
    longint unsigned lo, hi, v1, v2;
    int sel, e;
    window_of(lo, hi, v1, v2);
    sel = $urandom_range(0, 99);
    if (sel < 40 || hi == lo) return 14'($urandom());
    if (sel < 70) begin
      e = ($urandom_range(0, 1) ? int'(hi) : int'(lo)) + $urandom_range(0, 8) - 4;
      if (e < 0) e = 0;
      if (e > 16383) e = 16383;
      return 14'(e);
    end
    return 14'(lo + $urandom_range(0, int'(hi - lo - 1)));
  endfunction

  task automatic reg_write(input logic [2:0] ridx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {ridx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (ridx)
      dcp_pkg::REG_ROI_MODE:      cfg_mode = val[2:0];
      dcp_pkg::REG_CUSTOM_START:  cfg_cs = val[14:0];
      dcp_pkg::REG_CUSTOM_END:    cfg_ce = val[14:0];
      dcp_pkg::REG_REVERSE_ORDER: cfg_rev = val[0];
      dcp_pkg::REG_GRAY_MODE:     cfg_gray = val[0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic settle_pipe();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pix_q.size() != 0) @(negedge clk_i);
    repeat (PIPE_LAT + 3) @(negedge clk_i);
  endtask

  task automatic apply_config(input logic [2:0] mode, input logic [14:0] cs,
                              input logic [14:0] ce, input logic rev, input logic gray);
    settle_pipe();
    reg_write(dcp_pkg::REG_ROI_MODE, {29'd0, mode});
    reg_write(dcp_pkg::REG_CUSTOM_START, {17'd0, cs});
    reg_write(dcp_pkg::REG_CUSTOM_END, {17'd0, ce});
    reg_write(dcp_pkg::REG_REVERSE_ORDER, {31'd0, rev});
    reg_write(dcp_pkg::REG_GRAY_MODE, {31'd0, gray});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  // entered and left at a falling edge
  task automatic push_depth(input logic [13:0] idx, input logic typed, input rgba_t px);
    int gap;
    pix_exp_t e;
    gap = 0;
    while ($urandom_range(0, 99) < send_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    depth_index_i <= idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    e.idx = idx;
    e.px = typed ? px : palette_entry(idx);
    pix_q.push_back(e);
    @(negedge clk_i);
  endtask

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pix_q.size() == 0) begin
        $display("%0t: unexpected beat, got r=%0d g=%0d b=%0d a=%0d", $time,
                 red_o, green_o, blue_o, alpha_o);
        err_cnt++;
      end else begin
        pix_head = pix_q.pop_front();
        for (int c = 0; c < 4; c++) begin
          logic [7:0] want, got;
          want = pix_head.px[31 - 8 * c -: 8];
          got = (c == 0) ? red_o : (c == 1) ? green_o : (c == 2) ? blue_o : alpha_o;
          if (want !== got) begin
            $display("%0t: depth %0d channel %0d expected %0d actual %0d", $time,
                     pix_head.idx, c, want, got);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    while (stall_cnt < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cnt = 0;
      else stall_cnt++;
    end
    $display("tb_depth_to_color_palette_top: FAIL");
    $finish;
  end

  initial begin
    logic [2:0] mode;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    depth_index_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < N_ROWS; i++) begin
      if (DIR_ROWS[i].mode != cfg_mode || DIR_ROWS[i].cs != cfg_cs ||
          DIR_ROWS[i].ce != cfg_ce || DIR_ROWS[i].rev != cfg_rev ||
          DIR_ROWS[i].gray != cfg_gray)
        apply_config(DIR_ROWS[i].mode, DIR_ROWS[i].cs, DIR_ROWS[i].ce,
                     DIR_ROWS[i].rev, DIR_ROWS[i].gray);
      push_depth(DIR_ROWS[i].idx, DIR_ROWS[i].typed, DIR_ROWS[i].px);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_config(dcp_pkg::ROI_NORMAL, 15'd0, dcp_pkg::CUSTOM_END_RST, 1'b0, 1'b0);
        1: apply_config(dcp_pkg::ROI_CUSTOM, 15'd0, 15'd16384, 1'b1, 1'b0);
        2: apply_config(dcp_pkg::ROI_NORMAL, 15'd32767, 15'd0, 1'b1, 1'b1);
        default: begin
          mode = ($urandom_range(0, 2) == 0) ? dcp_pkg::ROI_CUSTOM
                                             : 3'($urandom_range(0, 7));
          apply_config(mode, bound_pick(), bound_pick(), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)));
        end
      endcase
      send_pct = (p < 4) ? 23 : (p < 8) ? 45 : 0;
      recv_pct = (p < 4) ? 45 : (p < 8) ? 23 : 0;
      for (int k = 0; k < PHASE_BEATS; k++) begin
        if (p == 9 && k == 20) hold_req = 1'b1;
        push_depth(depth_pick(), 1'b0, PX_CLEAR);
      end
    end

    settle_pipe();
    if (err_cnt == 0) begin
      $display("tb_depth_to_color_palette_top: PASS");
    end else begin
      $display("tb_depth_to_color_palette_top: FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/dcp_pkg.sv
rtl/depth_to_color_palette_top.sv
rtl/dcp_checker.sv
dv/tb_depth_to_color_palette_top.sv
